@@ design/ncs_pkg.sv @@
package ncs_pkg;

	// Table size and coordinate format.
	localparam int MAX_ENTRIES = 1024;
	localparam int COORD_BITS  = 16;

	// Fixed field widths of the ports.
	localparam int IN_COORD_W = 16;
	localparam int ID_W       = 16;
	localparam int DIST_W     = 34;

	// Derived widths.
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int PT_W  = 3 * COORD_BITS;

	// Request codes.
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	// Result status codes.
	localparam logic [1:0] STS_FOUND  = 2'd0;
	localparam logic [1:0] STS_EMPTY  = 2'd1;
	localparam logic [1:0] STS_LOADED = 2'd2;
	localparam logic [1:0] STS_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]                   req_type;
		logic signed [IN_COORD_W-1:0] coord_x;
		logic signed [IN_COORD_W-1:0] coord_y;
		logic signed [IN_COORD_W-1:0] coord_z;
		logic [ID_W-1:0]              elem_id;
	} req_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   best_id;
		logic [DIST_W-1:0] best_dist_sq;
		logic [1:0]        status;
	} rsp_item_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_EMIT
	} state_t;

	// Control that travels with each table read through the distance pipeline.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} scan_t;

	// Takes the low COORD_BITS bits of a coordinate field as a signed value.
	function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [IN_COORD_W-1:0] raw);
		logic [COORD_BITS+IN_COORD_W-1:0] wide;
		wide = {{COORD_BITS{1'b0}}, raw};
		return wide[COORD_BITS-1:0];
	endfunction

endpackage

@@ design/ncs_ram.sv @@
module ncs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/ncs_dist_unit.sv @@
module ncs_dist_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ncs_pkg::scan_t                      ctl,
	input  logic [ncs_pkg::PT_W-1:0]            cent,
	input  logic [ncs_pkg::ID_W-1:0]            id,
	input  logic [ncs_pkg::PT_W-1:0]            qry,
	output logic                                done,
	output logic [ncs_pkg::ID_W-1:0]            best_id,
	output logic [ncs_pkg::DIST_W-1:0]          best_dist
);

	localparam int C      = ncs_pkg::COORD_BITS;
	localparam int SQ_W   = 2 * C;
	localparam int SUM_W  = SQ_W + 2;
	localparam int WIDE_W = (SUM_W > ncs_pkg::DIST_W) ? SUM_W : ncs_pkg::DIST_W + 1;

	// Magnitude of a signed difference; it always fits in C bits.
	function automatic logic [C-1:0] mag(input logic signed [C:0] d);
		logic signed [C:0] n;
		n = -d;
		return d[C] ? n[C-1:0] : d[C-1:0];
	endfunction

	ncs_pkg::scan_t              ctl_s1, ctl_s2, ctl_s3;
	logic [ncs_pkg::ID_W-1:0]    id_s1, id_s2, id_s3;
	logic [C-1:0]                mx_s1, my_s1, mz_s1;
	logic [SQ_W-1:0]             sx_s2, sy_s2, sz_s2;
	logic [SUM_W-1:0]            sum_s3;
	logic [SUM_W-1:0]            best_q;
	logic [ncs_pkg::ID_W-1:0]    best_id_q;
	logic                        done_q;
	logic signed [C:0]           dx, dy, dz;
	logic [WIDE_W-1:0]           best_wide;

	// Per-axis differences between the stored centroid and the query point.
	assign dx = {cent[3*C-1], cent[3*C-1:2*C]} - {qry[3*C-1], qry[3*C-1:2*C]};
	assign dy = {cent[2*C-1], cent[2*C-1:C]} - {qry[2*C-1], qry[2*C-1:C]};
	assign dz = {cent[C-1], cent[C-1:0]} - {qry[C-1], qry[C-1:0]};

	// Control of the pipeline stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			done_q <= ctl_s3.valid && ctl_s3.last;
		end
	end

	// Stage 1 takes magnitudes, stage 2 squares them, stage 3 adds.
	always_ff @(posedge clk) begin
		mx_s1  <= mag(dx);
		my_s1  <= mag(dy);
		mz_s1  <= mag(dz);
		id_s1  <= id;
		sx_s2  <= SQ_W'(mx_s1 * mx_s1);
		sy_s2  <= SQ_W'(my_s1 * my_s1);
		sz_s2  <= SQ_W'(mz_s1 * mz_s1);
		id_s2  <= id_s1;
		sum_s3 <= SUM_W'(sx_s2) + SUM_W'(sy_s2) + SUM_W'(sz_s2);
		id_s3  <= id_s2;
	end

	// The first entry seeds the best; later ones replace it only when strictly nearer.
	always_ff @(posedge clk) begin
		if (ctl_s3.valid && (ctl_s3.first || (sum_s3 < best_q))) begin
			best_q    <= sum_s3;
			best_id_q <= id_s3;
		end
	end

	// Saturate to the width of the result field.
	assign best_wide = WIDE_W'(best_q);
	assign best_dist = (|best_wide[WIDE_W-1:ncs_pkg::DIST_W]) ? '1
		: best_wide[ncs_pkg::DIST_W-1:0];
	assign best_id   = best_id_q;
	assign done      = done_q;

	// Only the last entry of a scan may finish it.
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl_s3.valid) && $past(ctl_s3.last))
		else $error("distance unit finished without a last entry");

	// A scan always opens with its first entry.
	a_first_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s3.valid && ctl_s3.last) |-> $past(ctl_s3.valid) || ctl_s3.first)
		else $error("scan ended without a seeded best");

	// Stages advance in lockstep.
	a_stage_follow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid |=> ctl_s2.valid)
		else $error("pipeline stage lost an entry");

endmodule

@@ design/nearest_centroid_search_unit.sv @@
// Nearest centroid search over a table of up to MAX_ENTRIES 3D points.
// Load: writes the entry and returns LOADED, or returns FULL on a full table.
// Clear: resets the entry count, no result. Query on an empty table: returns EMPTY.
// Query on N entries: the read port feeds the distance pipeline one entry a cycle;
// no new request is taken until the result is registered.
// Reset clears the entry count and all control state; table contents are not cleared.
module nearest_centroid_search_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  ncs_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ncs_pkg::rsp_item_t rsp
);

	ncs_pkg::state_t                state_q, state_nxt;
	logic [ncs_pkg::CNT_W-1:0]      count_q;
	logic [ncs_pkg::CNT_W-1:0]      scan_q;
	logic [ncs_pkg::PT_W-1:0]       qry_q;
	ncs_pkg::rsp_item_t             res_q;
	ncs_pkg::rsp_item_t             rsp_q;
	logic                           rsp_valid_q;
	ncs_pkg::scan_t                 rd_ctl_q;
	logic                           accept;
	logic                           table_full;
	logic                           scan_last;
	logic                           issue;
	logic                           rsp_load;
	logic                           wr_en;
	logic [ncs_pkg::PT_W-1:0]       req_pt;
	logic [ncs_pkg::PT_W-1:0]       cent_rd;
	logic [ncs_pkg::ID_W-1:0]       id_rd;
	logic                           done;
	logic [ncs_pkg::ID_W-1:0]       best_id;
	logic [ncs_pkg::DIST_W-1:0]     best_dist;

	assign accept     = req_valid && !req_stall;
	assign table_full = (count_q == ncs_pkg::CNT_W'(ncs_pkg::MAX_ENTRIES));
	assign scan_last  = (scan_q == ncs_pkg::CNT_W'(count_q - ncs_pkg::CNT_W'(1)));
	assign req_pt     = {ncs_pkg::coord_of(req.coord_x), ncs_pkg::coord_of(req.coord_y),
		ncs_pkg::coord_of(req.coord_z)};
	assign wr_en      = accept && (req.req_type == ncs_pkg::REQ_LOAD) && !table_full;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ncs_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						ncs_pkg::REQ_LOAD:  state_nxt = ncs_pkg::ST_EMIT;
						ncs_pkg::REQ_QUERY: state_nxt = (count_q == '0) ? ncs_pkg::ST_EMIT
							: ncs_pkg::ST_SCAN;
						default:            state_nxt = ncs_pkg::ST_IDLE;
					endcase
				end
			end
			ncs_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_nxt = ncs_pkg::ST_WAIT;
				end
			end
			ncs_pkg::ST_WAIT: begin
				if (done) begin
					state_nxt = ncs_pkg::ST_EMIT;
				end
			end
			ncs_pkg::ST_EMIT: begin
				if (rsp_load) begin
					state_nxt = ncs_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ncs_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		req_stall = 1'b1;
		issue     = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ncs_pkg::ST_IDLE: req_stall = 1'b0;
			ncs_pkg::ST_SCAN: issue = 1'b1;
			ncs_pkg::ST_WAIT: issue = 1'b0;
			ncs_pkg::ST_EMIT: rsp_load = !rsp_valid_q || !rsp_stall;
			default:          req_stall = 1'b1;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ncs_pkg::ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
			rd_ctl_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept && (req.req_type == ncs_pkg::REQ_CLEAR)) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + ncs_pkg::CNT_W'(1);
			end
			if (accept) begin
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= scan_q + ncs_pkg::CNT_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			rd_ctl_q.valid <= issue;
			rd_ctl_q.first <= (scan_q == '0);
			rd_ctl_q.last  <= scan_last;
		end
	end

	// Query point, pending result and output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q <= req_pt;
			res_q.best_id      <= '0;
			res_q.best_dist_sq <= '0;
			if (req.req_type == ncs_pkg::REQ_LOAD) begin
				res_q.status <= table_full ? ncs_pkg::STS_FULL : ncs_pkg::STS_LOADED;
			end else begin
				res_q.status <= ncs_pkg::STS_EMPTY;
			end
		end else if ((state_q == ncs_pkg::ST_WAIT) && done) begin
			res_q.best_id      <= best_id;
			res_q.best_dist_sq <= best_dist;
			res_q.status       <= ncs_pkg::STS_FOUND;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Centroid and id tables share the write and read addresses.
	ncs_ram #(
		.WIDTH (ncs_pkg::PT_W),
		.DEPTH (ncs_pkg::MAX_ENTRIES)
	) u_cent_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ncs_pkg::IDX_W-1:0]),
		.wr_data (req_pt),
		.rd_en   (issue),
		.rd_addr (scan_q[ncs_pkg::IDX_W-1:0]),
		.rd_data (cent_rd)
	);

	ncs_ram #(
		.WIDTH (ncs_pkg::ID_W),
		.DEPTH (ncs_pkg::MAX_ENTRIES)
	) u_id_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ncs_pkg::IDX_W-1:0]),
		.wr_data (req.elem_id),
		.rd_en   (issue),
		.rd_addr (scan_q[ncs_pkg::IDX_W-1:0]),
		.rd_data (id_rd)
	);

	// Distance and compare pipeline.
	ncs_dist_unit u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rd_ctl_q),
		.cent      (cent_rd),
		.id        (id_rd),
		.qry       (qry_q),
		.done      (done),
		.best_id   (best_id),
		.best_dist (best_dist)
	);

	// The entry count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ncs_pkg::CNT_W'(ncs_pkg::MAX_ENTRIES))
		else $error("entry count beyond table size");

	// A scan finishes only while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ncs_pkg::ST_WAIT))
		else $error("distance result outside the wait state");

	// Reads stay within the filled part of the table.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (scan_q < count_q))
		else $error("scan reads an unfilled entry");

endmodule
